FILE: design/ncp_pkg.sv
// ----------------------------------------------------------------------------
// ncp_pkg
// Shared constants, field layout and controller/datapath interface types for
// the neighbour category proportions block.
// ----------------------------------------------------------------------------
`default_nettype none

package ncp_pkg;

    // Result layout: six Q1.16 shares (17 bits, 65536 = 1.0) and a total.
    localparam int OUT_BINS   = 6;
    localparam int PROP_W     = 17;
    localparam int CNT_W      = 8;
    localparam int CAT_W      = 3;
    localparam int ENTRY_W    = 4;
    localparam int VACANT_BIT = 3;
    localparam int MIN_BINS   = 2;
    localparam int ITER_W     = 5;

    // Reset value of the bin count register.
    localparam logic [CAT_W-1:0] BIN_COUNT_RESET = 3'd6;

    // Input request tdata layout, lowest bit first.
    localparam int IDX_W      = 12;
    localparam int IDX_LSB    = 0;
    localparam int OOR_BIT    = 12;
    localparam int CAT_LSB    = 13;
    localparam int EMPTY_BIT  = 16;
    localparam int IN_DATA_W  = 24;

    // Output tdata layout: prop_0 .. prop_5, then the total, zero padded.
    localparam int TOTAL_LSB  = OUT_BINS * PROP_W;
    localparam int OUT_DATA_W = 112;

    // Request kinds carried in tuser.
    localparam logic MODE_LOAD      = 1'b0;
    localparam logic MODE_NEIGHBOUR = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;    // an input request is taken this cycle
        logic count;     // store entry is on the read port: update counters
        logic div_step;  // one quotient bit of the shared divider
        logic load_out;  // move shares into the output register, clear counters
    } ncp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last;      // captured neighbour closes the cell
        logic iter_done; // divider is on the final quotient bit
        logic bin_done;  // divider is on the final bin
        logic out_free;  // output register can take a new result
    } ncp_stat_t;

endpackage

`default_nettype wire

FILE: design/ncp_ram.sv
// ----------------------------------------------------------------------------
// ncp_ram
// Generic single-port RAM with one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ncp_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    // Write on request, read the addressed word every cycle.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

FILE: design/ncp_datapath.sv
// ----------------------------------------------------------------------------
// ncp_datapath
// House store, bin and total counters, bit-serial divider for the shares and
// the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ncp_datapath
    import ncp_pkg::*;
#(
    parameter int CELLS         = 4096,
    parameter int MAX_NEIGHBORS = 24,
    parameter int NUM_BINS      = 6
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire ncp_cmd_t              cmd,
    output ncp_stat_t                  stat,
    input  wire logic                  mode,
    input  wire logic                  last_in,
    input  wire logic [IN_DATA_W-1:0]  in_data,
    input  wire logic                  cfg_valid,
    input  wire logic [CAT_W-1:0]      cfg_data,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic      [OUT_DATA_W-1:0] out_data
);

    localparam int AW    = $clog2(CELLS);
    localparam int LIM   = (NUM_BINS < OUT_BINS) ? NUM_BINS : OUT_BINS;
    localparam int BIN_W = 3;

    // Input field decode.
    logic [IDX_W-1:0]    in_idx;
    logic                in_oor;
    logic [CAT_W-1:0]    in_cat;
    logic                in_empty;
    logic                idx_ok;
    logic [AW+IDX_W-1:0] idx_ext;
    logic [AW-1:0]       ram_addr;
    logic                ram_we;
    logic [ENTRY_W-1:0]  ram_wdata;
    logic [ENTRY_W-1:0]  ram_rdata;

    assign in_idx    = in_data[IDX_LSB +: IDX_W];
    assign in_oor    = in_data[OOR_BIT];
    assign in_cat    = in_data[CAT_LSB +: CAT_W];
    assign in_empty  = in_data[EMPTY_BIT];
    assign idx_ok    = (32'(in_idx) < 32'(CELLS));
    assign idx_ext   = (AW+IDX_W)'(in_idx);
    assign ram_addr  = idx_ext[AW-1:0];
    assign ram_we    = cmd.accept && (mode == MODE_LOAD) && idx_ok;
    assign ram_wdata = {in_empty, in_cat};

    // House store; undefined until loaded.
    ncp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CELLS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Configuration register and effective bin count.
    logic [CAT_W-1:0] bin_count_reg;
    logic [CAT_W-1:0] nb;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_count_reg <= BIN_COUNT_RESET;
        end
        else if (cfg_valid)
        begin
            bin_count_reg <= cfg_data;
        end
    end

    always_comb
    begin
        nb = bin_count_reg;
        if (bin_count_reg < CAT_W'(MIN_BINS))
        begin
            nb = CAT_W'(MIN_BINS);
        end
        else if (bin_count_reg > CAT_W'(LIM))
        begin
            nb = CAT_W'(LIM);
        end
    end

    // Neighbour request fields held for the counting cycle.
    logic elig_reg;
    logic last_reg;
    logic [CNT_W-1:0] slot_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            elig_reg <= !in_oor && idx_ok && (slot_reg < CNT_W'(MAX_NEIGHBORS));
            last_reg <= last_in;
        end
    end

    // Counters: one bin per category, the total and the slot count.
    logic [CNT_W-1:0] cnt_reg [0:NUM_BINS-1];
    logic [CNT_W-1:0] total_reg;
    logic             hit;
    logic [CAT_W-1:0] hit_cat;

    assign hit_cat = ram_rdata[CAT_W-1:0];
    assign hit     = elig_reg && !ram_rdata[VACANT_BIT] && (hit_cat < nb);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < NUM_BINS; j++)
            begin
                cnt_reg[j] <= '0;
            end
            total_reg <= '0;
            slot_reg  <= '0;
        end
        else if (cmd.load_out)
        begin
            for (int j = 0; j < NUM_BINS; j++)
            begin
                cnt_reg[j] <= '0;
            end
            total_reg <= '0;
            slot_reg  <= '0;
        end
        else if (cmd.count)
        begin
            for (int j = 0; j < NUM_BINS; j++)
            begin
                if (hit && (hit_cat == CAT_W'(j)) && (cnt_reg[j] != '1))
                begin
                    cnt_reg[j] <= cnt_reg[j] + 1'b1;
                end
            end
            if (hit && (total_reg != '1))
            begin
                total_reg <= total_reg + 1'b1;
            end
            if (slot_reg != '1)
            begin
                slot_reg <= slot_reg + 1'b1;
            end
        end
    end

    // Restoring divider: count * 2^16 / total, one quotient bit per cycle.
    // A bin never exceeds the total, so the top bits of the dividend leave
    // count >> 1 as the starting remainder and 17 bits remain to resolve.
    logic [BIN_W-1:0]  bin_sel_reg;
    logic [ITER_W-1:0] iter_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [PROP_W-1:0] quo_reg;
    logic [PROP_W-1:0] prop_reg [0:OUT_BINS-1];
    logic [CNT_W-1:0]  sel_cnt;
    logic [CNT_W-1:0]  rem_base;
    logic              in_bit;
    logic [CNT_W:0]    trial;
    logic [CNT_W:0]    diff;
    logic              ge;
    logic [CNT_W-1:0]  rem_next;
    logic [PROP_W-1:0] quo_next;
    logic [PROP_W-1:0] prop_val;

    always_comb
    begin
        sel_cnt = '0;
        for (int j = 0; j < NUM_BINS; j++)
        begin
            if (bin_sel_reg == BIN_W'(j))
            begin
                sel_cnt = cnt_reg[j];
            end
        end
    end

    assign stat.iter_done = (iter_reg == ITER_W'(PROP_W - 1));
    assign stat.bin_done  = (bin_sel_reg == BIN_W'(OUT_BINS - 1));
    assign stat.last      = last_reg;

    always_comb
    begin
        rem_base = (iter_reg == '0) ? {1'b0, sel_cnt[CNT_W-1:1]} : rem_reg;
        in_bit   = (iter_reg == '0) ? sel_cnt[0] : 1'b0;
        trial    = {rem_base, in_bit};
        diff     = trial - {1'b0, total_reg};
        ge       = (trial >= {1'b0, total_reg});
        rem_next = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
        quo_next = {quo_reg[PROP_W-2:0], ge};
        // Bins outside the active count and an empty neighbourhood read zero.
        prop_val = ((bin_sel_reg < nb) && (total_reg != '0)) ? quo_next : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_sel_reg <= '0;
            iter_reg    <= '0;
        end
        else if (cmd.div_step)
        begin
            if (stat.iter_done)
            begin
                iter_reg    <= '0;
                bin_sel_reg <= stat.bin_done ? '0 : bin_sel_reg + 1'b1;
            end
            else
            begin
                iter_reg <= iter_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_step)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            if (stat.iter_done)
            begin
                prop_reg[bin_sel_reg] <= prop_val;
            end
        end
    end

    // Output register; a finished result waits here for the consumer.
    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [OUT_DATA_W-1:0] out_data_next;

    always_comb
    begin
        out_data_next = '0;
        for (int k = 0; k < OUT_BINS; k++)
        begin
            out_data_next[k*PROP_W +: PROP_W] = prop_reg[k];
        end
        out_data_next[TOTAL_LSB +: CNT_W] = total_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign stat.out_free = !out_valid_reg || out_ready;
    assign out_valid     = out_valid_reg;
    assign out_data      = out_data_reg;

endmodule

`default_nettype wire

FILE: design/ncp_ctrl.sv
// ----------------------------------------------------------------------------
// ncp_ctrl
// Controller: sequences store reads, counting, the share division and the
// hand-over to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ncp_ctrl
    import ncp_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    input  wire logic      mode,
    output logic           in_ready,
    input  wire ncp_stat_t stat,
    output ncp_cmd_t       cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COUNT,
        ST_DIV,
        ST_FLUSH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   ready_reg;
    logic   accept;

    assign accept   = in_valid && ready_reg;
    assign in_ready = ready_reg;

    // Command decode.
    assign cmd.accept   = accept;
    assign cmd.count    = (state_reg == ST_COUNT);
    assign cmd.div_step = (state_reg == ST_DIV);
    assign cmd.load_out = (state_reg == ST_FLUSH) && stat.out_free;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (mode == MODE_NEIGHBOUR))
                begin
                    state_next = ST_COUNT;
                end
            end
            ST_COUNT:
            begin
                state_next = stat.last ? ST_DIV : ST_IDLE;
            end
            ST_DIV:
            begin
                if (stat.iter_done && stat.bin_done)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered ready.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= (state_next == ST_IDLE);
        end
    end

endmodule

`default_nettype wire

FILE: design/neighbour_category_proportions.sv
// ----------------------------------------------------------------------------
// neighbour_category_proportions
// Per-cell histogram of neighbour categories, reported as Q1.16 shares.
// ----------------------------------------------------------------------------
// A load request writes a cell of the house store. A neighbour request
// first reads the store, then updates the counters. A neighbour request
// flagged as last then runs the shared bit-serial divider for 6 bins x 17
// quotient bits and then loads the output register. New requests are
// taken while a previous result still waits in the output register; a
// finished division waits only if that register is still occupied. The
// bin count may be written whenever no request is in flight; it is read
// when neighbours are counted and when shares are formed.
`default_nettype none

module neighbour_category_proportions
    import ncp_pkg::*;
#(
    parameter int CELLS         = 4096,
    parameter int MAX_NEIGHBORS = 24,
    parameter int NUM_BINS      = 6
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CAT_W-1:0]      cfg_data,       // bin_count
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // [11:0] cell_index, [12] out_of_range, [15:13] category, [16] empty_req
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  wire logic                  s_axis_tuser,   // [0] mode
    input  wire logic                  s_axis_tlast,   // last_neighbour
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // [16:0] prop_0, [33:17] prop_1, [50:34] prop_2, [67:51] prop_3,
    // [84:68] prop_4, [101:85] prop_5, [109:102] valid_total
    output logic      [OUT_DATA_W-1:0] m_axis_tdata
);

    ncp_cmd_t  cmd;
    ncp_stat_t stat;

    // The bin count register is always writable.
    assign cfg_ready = 1'b1;

    ncp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .mode     (s_axis_tuser),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ncp_datapath #(
        .CELLS         (CELLS),
        .MAX_NEIGHBORS (MAX_NEIGHBORS),
        .NUM_BINS      (NUM_BINS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .mode      (s_axis_tuser),
        .last_in   (s_axis_tlast),
        .in_data   (s_axis_tdata),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule

`default_nettype wire

FILE: design/ncp_checker.sv
// ----------------------------------------------------------------------------
// ncp_checker
// Port-level checks for neighbour_category_proportions, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module ncp_checker
    import ncp_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  s_axis_tvalid,
    input wire logic                  s_axis_tready,
    input wire logic                  s_axis_tuser,
    input wire logic                  m_axis_tvalid,
    input wire logic                  m_axis_tready,
    input wire logic [OUT_DATA_W-1:0] m_axis_tdata
);

    localparam logic [PROP_W-1:0] ONE = 17'h10000;

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result request dropped while stalled");

    // A stalled result keeps its payload.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result payload changed while stalled");

    // While the counters update for a taken neighbour request, no new request is taken.
    a_nb_two_cycles: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == MODE_NEIGHBOUR)
        |=> !s_axis_tready)
        else $error("request taken during counter update");

    // An empty neighbourhood reports all shares as zero.
    a_zero_total: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[TOTAL_LSB +: CNT_W] == '0)
        |-> (m_axis_tdata[TOTAL_LSB-1:0] == '0))
        else $error("nonzero share with zero total");

    // No share exceeds one and the padding stays clear.
    a_share_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            (m_axis_tdata[16:0] <= ONE) && (m_axis_tdata[33:17] <= ONE) &&
            (m_axis_tdata[50:34] <= ONE) && (m_axis_tdata[67:51] <= ONE) &&
            (m_axis_tdata[84:68] <= ONE) && (m_axis_tdata[101:85] <= ONE) &&
            (m_axis_tdata[OUT_DATA_W-1:TOTAL_LSB+CNT_W] == '0))
        else $error("share out of range or padding set");

endmodule

bind neighbour_category_proportions ncp_checker u_ncp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
